### src/sfr_pkg.sv
// shared types and constants of the stuffed frame receiver
`timescale 1ns / 1ps

package sfr_pkg;

  localparam int MAX_FRAME = 64;
  localparam int CNT_W     = $clog2(MAX_FRAME + 1);
  localparam int CMP_W     = (CNT_W > 8) ? CNT_W : 8;
  localparam int IDX_W     = 6;
  localparam int LEN_W     = 7;
  localparam int Q_DEPTH   = 2;
  localparam int PTR_W     = $clog2(Q_DEPTH);
  localparam int QCNT_W    = $clog2(Q_DEPTH + 1);

  localparam logic [7:0] BYTE_START = 8'hFD;
  localparam logic [7:0] BYTE_STOP  = 8'hFE;
  localparam logic [7:0] BYTE_ESC   = 8'hFF;

  localparam logic [1:0] CFG_CRC_INIT = 2'd0;
  localparam logic [1:0] CFG_CRC_POLY = 2'd1;
  localparam logic [1:0] CFG_MIN_LEN  = 2'd2;

  localparam logic [15:0] CRC_INIT_RST = 16'hFFFF;
  localparam logic [15:0] CRC_POLY_RST = 16'h1021;
  localparam logic [7:0]  MIN_LEN_RST  = 8'd7;

  typedef enum logic [1:0] {
    CMD_DATA,
    CMD_START,
    CMD_STOP,
    CMD_ESC
  } cmd_kind_e;

  typedef enum logic [2:0] {
    EV_NONE  = 3'd0,
    EV_BYTE  = 3'd1,
    EV_GOOD  = 3'd2,
    EV_SHORT = 3'd3,
    EV_BAD   = 3'd4
  } event_e;

  typedef struct packed {
    cmd_kind_e  kind;
    logic [7:0] data;
  } cmd_t;

  typedef struct packed {
    event_e           ev;
    logic [7:0]       data;
    logic [IDX_W-1:0] index;
    logic [LEN_W-1:0] len;
  } res_t;

endpackage

### src/sfr_front.sv
// front end: byte classification and command queue
`timescale 1ns / 1ps

module sfr_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push,
  output logic            full,
  input  logic [7:0]      byte_in_i,
  input  logic            cmd_pop_i,
  output logic            cmd_valid_o,
  output sfr_pkg::cmd_t   cmd_o
);

  sfr_pkg::cmd_t                    mem_q [sfr_pkg::Q_DEPTH];
  logic [sfr_pkg::PTR_W-1:0]        wr_q, rd_q;
  logic [sfr_pkg::QCNT_W-1:0]       cnt_q;
  sfr_pkg::cmd_t                    cmd_new;
  logic                             do_push, do_pop;

  always_comb begin
    cmd_new.data = byte_in_i;
    unique case (byte_in_i)
      sfr_pkg::BYTE_START: cmd_new.kind = sfr_pkg::CMD_START;
      sfr_pkg::BYTE_STOP:  cmd_new.kind = sfr_pkg::CMD_STOP;
      sfr_pkg::BYTE_ESC:   cmd_new.kind = sfr_pkg::CMD_ESC;
      default:             cmd_new.kind = sfr_pkg::CMD_DATA;
    endcase
  end

  assign full        = (cnt_q == sfr_pkg::QCNT_W'(sfr_pkg::Q_DEPTH));
  assign cmd_valid_o = (cnt_q != '0);
  assign cmd_o       = mem_q[rd_q];
  assign do_push     = push && !full;
  assign do_pop      = cmd_pop_i && cmd_valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wr_q <= wr_q + sfr_pkg::PTR_W'(1);
      if (do_pop)  rd_q <= rd_q + sfr_pkg::PTR_W'(1);
      if (do_push && !do_pop)      cnt_q <= cnt_q + sfr_pkg::QCNT_W'(1);
      else if (!do_push && do_pop) cnt_q <= cnt_q - sfr_pkg::QCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= cmd_new;
  end

endmodule

### src/sfr_back.sv
// back end: frame state, destuffing, crc check and config registers
`timescale 1ns / 1ps

module sfr_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_valid_i,
  output logic            cfg_ready_o,
  input  logic [1:0]      cfg_index_i,
  input  logic [15:0]     cfg_data_i,
  input  logic            cmd_valid_i,
  input  sfr_pkg::cmd_t   cmd_i,
  output logic            cmd_pop_o,
  input  logic            res_full_i,
  output logic            res_push_o,
  output sfr_pkg::res_t   res_o
);

  typedef enum logic [1:0] {
    MODE_STOPPED,
    MODE_RECV,
    MODE_ESC
  } mode_e;

  mode_e                        mode_q, mode_d;
  logic [sfr_pkg::CNT_W-1:0]    cnt_q, cnt_d, cnt_inc;
  logic [15:0]                  crc_q, crc_d;
  logic [7:0]                   tail0_q, tail0_d, tail1_q, tail1_d;
  logic [15:0]                  crc_init_q, crc_poly_q;
  logic [7:0]                   min_len_q;
  logic [sfr_pkg::CMP_W-1:0]    cnt_w, len_w;
  logic [7:0]                   stored;
  logic                         store_en, fire;

  function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b,
                                           input logic [15:0] poly);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      c = c[15] ? ((c << 1) ^ poly) : (c << 1);
    end
    return c;
  endfunction

  assign fire        = cmd_valid_i && !res_full_i;
  assign cmd_pop_o   = fire;
  assign res_push_o  = fire;
  assign cfg_ready_o = 1'b1;

  always_comb begin
    mode_d    = mode_q;
    cnt_d     = cnt_q;
    crc_d     = crc_q;
    tail0_d   = tail0_q;
    tail1_d   = tail1_q;
    store_en  = 1'b0;
    res_o     = '{ev: sfr_pkg::EV_NONE, data: '0, index: '0, len: '0};
    stored    = (mode_q == MODE_ESC) ? ~cmd_i.data : cmd_i.data;
    cnt_w     = sfr_pkg::CMP_W'(cnt_q);
    len_w     = cnt_w - sfr_pkg::CMP_W'(2);
    cnt_inc   = cnt_q + sfr_pkg::CNT_W'(1);
    unique case (cmd_i.kind)
      sfr_pkg::CMD_START: begin
        cnt_d   = '0;
        mode_d  = MODE_RECV;
        crc_d   = crc_init_q;
        tail0_d = '0;
        tail1_d = '0;
      end
      sfr_pkg::CMD_STOP: begin
        if (mode_q == MODE_RECV) begin
          mode_d = MODE_STOPPED;
          if (cnt_w < sfr_pkg::CMP_W'(min_len_q) || cnt_q < sfr_pkg::CNT_W'(2)) begin
            res_o.ev = sfr_pkg::EV_SHORT;
          end else begin
            res_o.ev  = ({tail0_q, tail1_q} == crc_q) ? sfr_pkg::EV_GOOD : sfr_pkg::EV_BAD;
            res_o.len = len_w[sfr_pkg::LEN_W-1:0];
          end
        end
      end
      sfr_pkg::CMD_ESC: begin
        if (mode_q == MODE_RECV)     mode_d = MODE_ESC;
        else if (mode_q == MODE_ESC) store_en = 1'b1;
        else                         cnt_d = '0;
      end
      sfr_pkg::CMD_DATA: begin
        store_en = (mode_q != MODE_STOPPED);
      end
    endcase
    if (store_en) begin
      mode_d = MODE_RECV;
      if (cnt_q >= sfr_pkg::CNT_W'(2)) crc_d = crc_feed(crc_q, tail0_q, crc_poly_q);
      tail0_d = tail1_q;
      tail1_d = stored;
      cnt_d   = cnt_inc;
      if (cnt_inc >= sfr_pkg::CNT_W'(sfr_pkg::MAX_FRAME)) mode_d = MODE_STOPPED;
      res_o.ev    = sfr_pkg::EV_BYTE;
      res_o.data  = stored;
      res_o.index = cnt_w[sfr_pkg::IDX_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= MODE_STOPPED;
      cnt_q      <= '0;
      crc_q      <= '0;
      tail0_q    <= '0;
      tail1_q    <= '0;
      crc_init_q <= sfr_pkg::CRC_INIT_RST;
      crc_poly_q <= sfr_pkg::CRC_POLY_RST;
      min_len_q  <= sfr_pkg::MIN_LEN_RST;
    end else begin
      if (fire) begin
        mode_q  <= mode_d;
        cnt_q   <= cnt_d;
        crc_q   <= crc_d;
        tail0_q <= tail0_d;
        tail1_q <= tail1_d;
      end
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          sfr_pkg::CFG_CRC_INIT: crc_init_q <= cfg_data_i;
          sfr_pkg::CFG_CRC_POLY: crc_poly_q <= cfg_data_i;
          sfr_pkg::CFG_MIN_LEN:  min_len_q  <= cfg_data_i[7:0];
          default: ;
        endcase
      end
    end
  end

`ifndef SYNTH
  a_byte_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && res_o.ev == sfr_pkg::EV_BYTE |=> cnt_q == $past(cnt_q) + sfr_pkg::CNT_W'(1))
    else $error("stored byte did not advance the count");

  a_open_frame_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mode_q != MODE_STOPPED |-> cnt_q < sfr_pkg::CNT_W'(sfr_pkg::MAX_FRAME))
    else $error("open frame at full length");

  a_end_stops: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && (res_o.ev == sfr_pkg::EV_GOOD || res_o.ev == sfr_pkg::EV_BAD ||
             res_o.ev == sfr_pkg::EV_SHORT) |=> mode_q == MODE_STOPPED)
    else $error("frame end left receiver open");
`endif

endmodule

### src/sfr_outq.sv
// result queue between back end and result port
`timescale 1ns / 1ps

module sfr_outq (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            res_push_i,
  input  sfr_pkg::res_t   res_i,
  output logic            res_full_o,
  input  logic            pop,
  output logic            empty,
  output sfr_pkg::res_t   res_o
);

  sfr_pkg::res_t                mem_q [sfr_pkg::Q_DEPTH];
  logic [sfr_pkg::PTR_W-1:0]    wr_q, rd_q;
  logic [sfr_pkg::QCNT_W-1:0]   cnt_q;
  logic                         do_push, do_pop;

  assign res_full_o = (cnt_q == sfr_pkg::QCNT_W'(sfr_pkg::Q_DEPTH));
  assign empty      = (cnt_q == '0);
  assign res_o      = mem_q[rd_q];
  assign do_push    = res_push_i && !res_full_o;
  assign do_pop     = pop && !empty;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wr_q <= wr_q + sfr_pkg::PTR_W'(1);
      if (do_pop)  rd_q <= rd_q + sfr_pkg::PTR_W'(1);
      if (do_push && !do_pop)      cnt_q <= cnt_q + sfr_pkg::QCNT_W'(1);
      else if (!do_push && do_pop) cnt_q <= cnt_q - sfr_pkg::QCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= res_i;
  end

endmodule

### src/stuffed_frame_receiver_crc16_top.sv
// top level of the byte-stuffed frame receiver with crc-16 check
//
//  channel   direction  handshake            payload
//  input     in         push / full          byte_in_i
//  result    out        empty / pop          event_res_o data_byte_o byte_index_o frame_length_o
//  config    in         cfg_valid_i / ready  cfg_index_i cfg_data_i
//
// one request per cycle unless results back up; crc byte update is a combinational xor network
// a taken request passes the command queue and then the result queue to the result ports
// two-entry queues sit after the byte classifier and after the back end
// asynchronous active-low reset, no clearing pass; config ready is always high
`timescale 1ns / 1ps

module stuffed_frame_receiver_crc16_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  byte_in_i,
  output logic        empty,
  input  logic        pop,
  output logic [2:0]  event_res_o,
  output logic [7:0]  data_byte_o,
  output logic [5:0]  byte_index_o,
  output logic [6:0]  frame_length_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  sfr_pkg::cmd_t cmd;
  sfr_pkg::res_t res_new, res_head;
  logic          cmd_valid, cmd_pop, res_push, res_full;

  sfr_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .byte_in_i   (byte_in_i),
    .cmd_pop_i   (cmd_pop),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd)
  );

  sfr_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .res_full_i  (res_full),
    .res_push_o  (res_push),
    .res_o       (res_new)
  );

  sfr_outq u_outq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .res_push_i (res_push),
    .res_i      (res_new),
    .res_full_o (res_full),
    .pop        (pop),
    .empty      (empty),
    .res_o      (res_head)
  );

  assign event_res_o    = res_head.ev;
  assign data_byte_o    = res_head.data;
  assign byte_index_o   = res_head.index;
  assign frame_length_o = res_head.len;

endmodule

### sim/stuffed_frame_receiver_crc16_checker.sv
// checker: predicts every event of the frame receiver and compares it with the result port
`timescale 1ns / 1ps

module stuffed_frame_receiver_crc16_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  input  logic        full,
  input  logic [7:0]  byte_in_i,
  input  logic        empty,
  input  logic        pop,
  input  logic [2:0]  event_res_i,
  input  logic [7:0]  data_byte_i,
  input  logic [5:0]  byte_index_i,
  input  logic [6:0]  frame_length_i,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  output int          errors_o,
  output int          pending_o,
  output int          checked_o,
  output int          good_o,
  output int          too_short_o,
  output int          crc_bad_o
);

  import sfr_pkg::*;

  typedef enum logic [1:0] {
    RX_IDLE,
    RX_DATA,
    RX_ESC
  } rx_state_e;

  logic [15:0] cfg_init;
  logic [15:0] cfg_poly;
  logic [7:0]  cfg_min;

  rx_state_e   rx_state;
  int          byte_cnt;
  logic [15:0] crc_acc;
  logic [7:0]  tail_hi;
  logic [7:0]  tail_lo;

  res_t expected_events[$];
  res_t want;

  int err_cnt   = 0;
  int queued    = 0;
  int compared  = 0;
  int n_good    = 0;
  int n_short   = 0;
  int n_crc_bad = 0;

  assign errors_o    = err_cnt;
  assign pending_o   = queued;
  assign checked_o   = compared;
  assign good_o      = n_good;
  assign too_short_o = n_short;
  assign crc_bad_o   = n_crc_bad;

  function automatic logic [15:0] crc16_byte(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (c[15]) begin
        c = (c << 1) ^ cfg_poly;
      end else begin
        c = c << 1;
      end
    end
    return c;
  endfunction

  // advances the receiver state by one line byte and returns the event it reports
  function automatic res_t receive_byte(logic [7:0] b);
    res_t       r;
    logic [7:0] v;
    r = '0;
    r.ev = EV_NONE;
    if (b == BYTE_START) begin
      byte_cnt = 0;
      rx_state = RX_DATA;
      crc_acc  = cfg_init;
      tail_hi  = 8'h00;
      tail_lo  = 8'h00;
      return r;
    end
    if (b == BYTE_STOP) begin
      if (rx_state == RX_DATA) begin
        rx_state = RX_IDLE;
        if (byte_cnt < int'(cfg_min) || byte_cnt < 2) begin
          r.ev = EV_SHORT;
        end else begin
          r.ev  = ({tail_hi, tail_lo} == crc_acc) ? EV_GOOD : EV_BAD;
          r.len = LEN_W'(byte_cnt - 2);
        end
      end
      return r;
    end
    if (b == BYTE_ESC && rx_state == RX_DATA) begin
      rx_state = RX_ESC;
      return r;
    end
    case (rx_state)
      RX_DATA: v = b;
      RX_ESC: begin
        rx_state = RX_DATA;
        v = 8'hFF - b;
      end
      default: begin
        // escape outside a frame clears the byte count
        if (b == BYTE_ESC) byte_cnt = 0;
        return r;
      end
    endcase
    r.ev    = EV_BYTE;
    r.data  = v;
    r.index = IDX_W'(byte_cnt);
    // the two newest bytes are held back as the received crc
    if (byte_cnt >= 2) crc_acc = crc16_byte(crc_acc, tail_hi);
    tail_hi  = tail_lo;
    tail_lo  = v;
    byte_cnt = byte_cnt + 1;
    if (byte_cnt >= MAX_FRAME) rx_state = RX_IDLE;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_init <= CRC_INIT_RST;
      cfg_poly <= CRC_POLY_RST;
      cfg_min  <= MIN_LEN_RST;
      rx_state <= RX_IDLE;
      byte_cnt <= 0;
      crc_acc  <= 16'h0000;
      tail_hi  <= 8'h00;
      tail_lo  <= 8'h00;
      expected_events.delete();
      queued   <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_CRC_INIT: cfg_init = cfg_data_i;
          CFG_CRC_POLY: cfg_poly = cfg_data_i;
          CFG_MIN_LEN:  cfg_min  = cfg_data_i[7:0];
          default: ;
        endcase
      end
      if (pop && !empty) begin
        if (expected_events.size() == 0) begin
          $error("unexpected result: event_res %0d data_byte %0d byte_index %0d frame_length %0d",
                 event_res_i, data_byte_i, byte_index_i, frame_length_i);
          err_cnt++;
        end else begin
          want = expected_events.pop_front();
          compared++;
          if (event_res_i !== want.ev) begin
            $error("event_res mismatch: expected %0d, got %0d", want.ev, event_res_i);
            err_cnt++;
          end
          if (data_byte_i !== want.data) begin
            $error("data_byte mismatch: expected %0d, got %0d", want.data, data_byte_i);
            err_cnt++;
          end
          if (byte_index_i !== want.index) begin
            $error("byte_index mismatch: expected %0d, got %0d", want.index, byte_index_i);
            err_cnt++;
          end
          if (frame_length_i !== want.len) begin
            $error("frame_length mismatch: expected %0d, got %0d", want.len, frame_length_i);
            err_cnt++;
          end
          case (want.ev)
            EV_GOOD:  n_good++;
            EV_SHORT: n_short++;
            EV_BAD:   n_crc_bad++;
            default: ;
          endcase
        end
      end
      if (push && !full) expected_events.push_back(receive_byte(byte_in_i));
      queued <= expected_events.size();
    end
  end

endmodule

### sim/stuffed_frame_receiver_crc16_top_test.sv
// testbench top: drives line bytes and register writes into the frame receiver and gives the verdict
`timescale 1ns / 1ps

module stuffed_frame_receiver_crc16_top_test;

  import sfr_pkg::*;

  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  logic        push      = 1'b0;
  logic        full;
  logic [7:0]  byte_in   = 8'h00;
  logic        empty;
  logic        pop       = 1'b0;
  logic [2:0]  event_res;
  logic [7:0]  data_byte;
  logic [5:0]  byte_index;
  logic [6:0]  frame_length;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = 2'd0;
  logic [15:0] cfg_data  = 16'h0000;

  int errors;
  int pending;
  int checked;
  int n_good;
  int n_short;
  int n_crc_bad;

  logic [15:0] cur_init = CRC_INIT_RST;
  logic [15:0] cur_poly = CRC_POLY_RST;
  logic [7:0]  cur_min  = MIN_LEN_RST;

  logic [7:0] line_seq[$];
  bit         no_gap     = 1'b0;
  bit         hold_req   = 1'b0;
  int         bytes_sent = 0;
  int         settings   = 1;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  stuffed_frame_receiver_crc16_top dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .push           (push),
    .full           (full),
    .byte_in_i      (byte_in),
    .empty          (empty),
    .pop            (pop),
    .event_res_o    (event_res),
    .data_byte_o    (data_byte),
    .byte_index_o   (byte_index),
    .frame_length_o (frame_length),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data)
  );

  stuffed_frame_receiver_crc16_checker u_check (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .push           (push),
    .full           (full),
    .byte_in_i      (byte_in),
    .empty          (empty),
    .pop            (pop),
    .event_res_i    (event_res),
    .data_byte_i    (data_byte),
    .byte_index_i   (byte_index),
    .frame_length_i (frame_length),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_i    (cfg_ready),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data),
    .errors_o       (errors),
    .pending_o      (pending),
    .checked_o      (checked),
    .good_o         (n_good),
    .too_short_o    (n_short),
    .crc_bad_o      (n_crc_bad)
  );

  function automatic int draw_gap();
    return no_gap ? 0 : $urandom_range(0, 6);
  endfunction

  function automatic int draw_len();
    int r;
    r = $urandom_range(0, 19);
    if (r < 16) return $urandom_range(0, 12);
    if (r < 19) return $urandom_range(13, 40);
    return $urandom_range(60, 70);
  endfunction

  // crc for building frames with a matching check value
  function automatic logic [15:0] frame_crc(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    repeat (8) c = c[15] ? ((c << 1) ^ cur_poly) : (c << 1);
    return c;
  endfunction

  task automatic offer_byte(input logic [7:0] b);
    int gap;
    gap = draw_gap();
    @(negedge clk);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    push    <= 1'b1;
    byte_in <= b;
    do @(posedge clk); while (full);
    bytes_sent++;
  endtask

  task automatic send_seq();
    foreach (line_seq[i]) offer_byte(line_seq[i]);
    line_seq.delete();
  endtask

  task automatic settle();
    @(negedge clk);
    push <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_CRC_INIT: cur_init = val;
      CFG_CRC_POLY: cur_poly = val;
      CFG_MIN_LEN:  cur_min  = val[7:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_config(input logic [15:0] init, input logic [15:0] poly,
                            input logic [7:0] minl);
    settle();
    write_reg(CFG_CRC_INIT, init);
    write_reg(CFG_CRC_POLY, poly);
    write_reg(CFG_MIN_LEN, {8'h00, minl});
    settings++;
  endtask

  // start, stuffed payload plus crc, stop
  task automatic make_frame(input int n, input bit corrupt);
    logic [7:0]  body[$];
    logic [15:0] crc;
    int          i;
    int          pos;
    crc = cur_init;
    for (i = 0; i < n; i++) begin
      body.push_back(8'($urandom_range(0, 255)));
      crc = frame_crc(crc, body[i]);
    end
    body.push_back(crc[15:8]);
    body.push_back(crc[7:0]);
    if (corrupt) begin
      pos = $urandom_range(0, body.size() - 1);
      body[pos] ^= 8'(1 << $urandom_range(0, 7));
    end
    line_seq.push_back(BYTE_START);
    foreach (body[k]) begin
      if (body[k] >= BYTE_START || (body[k] > 8'h02 && $urandom_range(0, 7) == 0)) begin
        line_seq.push_back(BYTE_ESC);
        line_seq.push_back(8'hFF - body[k]);
      end else begin
        line_seq.push_back(body[k]);
      end
    end
    line_seq.push_back(BYTE_STOP);
  endtask

  task automatic random_phase(input int quota, input bit all_burst);
    int counted;
    int r;
    int k;
    counted = 0;
    while (counted < quota) begin
      r = $urandom_range(0, 99);
      no_gap = all_burst || ($urandom_range(0, 5) == 0);
      if (r < 15) begin
        // line noise between frames
        k = $urandom_range(1, 6);
        repeat (k) line_seq.push_back(8'($urandom_range(0, 255)));
        send_seq();
      end else begin
        make_frame(draw_len(), (r < 80) ? ($urandom_range(0, 4) == 0) : 1'b0);
        if (r >= 80 && r < 90) begin
          k = $urandom_range(1, line_seq.size() - 1);
          while (line_seq.size() > k) void'(line_seq.pop_back());
        end else if (r >= 90) begin
          k = $urandom_range(1, line_seq.size() - 1);
          case ($urandom_range(0, 2))
            0: begin
              line_seq.insert(k, BYTE_STOP);
              line_seq.insert(k, BYTE_ESC);
            end
            1: begin
              line_seq.insert(k, BYTE_ESC);
              line_seq.insert(k, BYTE_ESC);
            end
            default: line_seq.insert(k, BYTE_START);
          endcase
        end
        counted += line_seq.size();
        send_seq();
      end
    end
    no_gap = 1'b0;
  endtask

  task automatic directed_cases();
    logic [7:0] opening[16];
    opening = '{BYTE_STOP, BYTE_ESC, 8'h00, 8'h80,
                BYTE_START, BYTE_ESC, BYTE_ESC,
                BYTE_ESC, BYTE_STOP, 8'h00,
                BYTE_ESC, BYTE_START, 8'h7F, BYTE_STOP,
                BYTE_START, BYTE_STOP};
    foreach (opening[i]) line_seq.push_back(opening[i]);
    send_seq();
    make_frame(5, 1'b0);
    send_seq();
  endtask

  // result side
  initial begin
    int gap;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      gap = hold_req ? 80 : draw_gap();
      hold_req = 1'b0;
      if (gap > 0) begin
        pop <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      pop <= 1'b1;
      do @(posedge clk); while (empty);
    end
  end

  initial begin
    #5_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    directed_cases();
    random_phase(200, 1'b0);
    set_config(16'h0000, 16'h8005, 8'd3);
    hold_req = 1'b1;
    random_phase(200, 1'b0);
    set_config(16'hFFFF, 16'hFFFF, 8'd255);
    random_phase(120, 1'b0);
    set_config(16'h0000, 16'h0000, 8'd3);
    random_phase(150, 1'b1);
    repeat (3) begin
      set_config(16'($urandom), 16'($urandom), 8'($urandom_range(3, 20)));
      random_phase(180, 1'b0);
    end
    set_config(16'h1D0F, 16'h1021, 8'd5);
    random_phase(150, 1'b0);
    settle();
    repeat (8) @(negedge clk);
    $display("run covered %0d line bytes under %0d register settings, %0d results compared",
             bytes_sent, settings, checked);
    $display("frame ends seen: %0d good, %0d too short, %0d crc mismatch",
             n_good, n_short, n_crc_bad);
    if (errors == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
